>>> rtl/core/liir_pkg.sv
// Shared constants and types for the look-ahead first-order IIR filter.
// Holds the register map and coefficient reset values; no dependencies.
package liir_pkg;

   // Register port geometry: four 32-bit registers at byte addresses 4*i
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_LSB  = 2;

   // Register indexes
   typedef enum logic [1:0] {
      REG_COEF_DIRECT     = 2'd0,
      REG_COEF_FIRST_LAG  = 2'd1,
      REG_COEF_SECOND_LAG = 2'd2,
      REG_COEF_FEEDBACK   = 2'd3
   } reg_index_type;

   // Coefficient reset values, truncated to the sample width where used
   localparam int COEF_DIRECT_RESET     = 430;
   localparam int COEF_FIRST_LAG_RESET  = 499;
   localparam int COEF_SECOND_LAG_RESET = -69;
   localparam int COEF_FEEDBACK_RESET   = 25;

endpackage

>>> rtl/core/lookahead_iir_first_order.sv
// Look-ahead first-order IIR filter, one sample in and one sample out per beat.
// Latency: the result beat is valid the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the output register is refilled in the same
// cycle it is drained, so the input stalls only while a result is held back.
// Reset (synchronous, active high) zeroes all filter state, empties the output
// register and loads the coefficient defaults. Uses liir_pkg, liir_csr, liir_datapath.
module lookahead_iir_first_order
   import liir_pkg::*;
#(
   parameter int SAMPLE_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS:0]   rsp_sample_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   logic signed [SAMPLE_BITS-1:0] coef_direct;
   logic signed [SAMPLE_BITS-1:0] coef_first_lag;
   logic signed [SAMPLE_BITS-1:0] coef_second_lag;
   logic signed [SAMPLE_BITS-1:0] coef_feedback;
   logic signed [SAMPLE_BITS:0]   filter_out;
   logic                          accept;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS:0]   rsp_sample_ff;

   liir_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .coef_direct     (coef_direct),
      .coef_first_lag  (coef_first_lag),
      .coef_second_lag (coef_second_lag),
      .coef_feedback   (coef_feedback)
   );

   liir_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .advance         (accept),
      .sample_in       (req_sample_in),
      .coef_direct     (coef_direct),
      .coef_first_lag  (coef_first_lag),
      .coef_second_lag (coef_second_lag),
      .coef_feedback   (coef_feedback),
      .sample_out      (filter_out)
   );

   // Input is held off only while a result beat waits on a stalled sink
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sample_ff <= filter_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // An accepted beat always shows up as a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted beat produced no result");

   // A held-back result must block new input
   assert property (@(posedge clock)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result stalled");

   // Reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

>>> rtl/core/liir_csr.sv
// Coefficient register file with an APB-style access port.
// Depends on liir_pkg for the register map and reset values.
module liir_csr
   import liir_pkg::*;
#(
   parameter int SAMPLE_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready,
   output logic signed [SAMPLE_BITS-1:0] coef_direct,
   output logic signed [SAMPLE_BITS-1:0] coef_first_lag,
   output logic signed [SAMPLE_BITS-1:0] coef_second_lag,
   output logic signed [SAMPLE_BITS-1:0] coef_feedback
);

   localparam logic [SAMPLE_BITS-1:0] DIRECT_RST     = SAMPLE_BITS'(COEF_DIRECT_RESET);
   localparam logic [SAMPLE_BITS-1:0] FIRST_LAG_RST  = SAMPLE_BITS'(COEF_FIRST_LAG_RESET);
   localparam logic [SAMPLE_BITS-1:0] SECOND_LAG_RST = SAMPLE_BITS'(COEF_SECOND_LAG_RESET);
   localparam logic [SAMPLE_BITS-1:0] FEEDBACK_RST   = SAMPLE_BITS'(COEF_FEEDBACK_RESET);

   logic signed [SAMPLE_BITS-1:0] coef_direct_ff;
   logic signed [SAMPLE_BITS-1:0] coef_first_lag_ff;
   logic signed [SAMPLE_BITS-1:0] coef_second_lag_ff;
   logic signed [SAMPLE_BITS-1:0] coef_feedback_ff;
   logic                          write_hit;
   reg_index_type                 reg_index;
   logic [SAMPLE_BITS-1:0]        write_value;

   // Sign-extend a coefficient to the bus width for read-back
   function automatic logic [CSR_DATA_BITS-1:0] widen(input logic [SAMPLE_BITS-1:0] c);
      logic [CSR_DATA_BITS-1:0] w;
      w = {{(CSR_DATA_BITS-SAMPLE_BITS){c[SAMPLE_BITS-1]}}, c};
      return w;
   endfunction

   assign csr_pready  = 1'b1;
   assign write_hit   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index   = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_WORD_LSB]);
   assign write_value = csr_pwdata[SAMPLE_BITS-1:0];

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_direct_ff     <= DIRECT_RST;
         coef_first_lag_ff  <= FIRST_LAG_RST;
         coef_second_lag_ff <= SECOND_LAG_RST;
         coef_feedback_ff   <= FEEDBACK_RST;
      end else if (write_hit) begin
         case (reg_index)
            REG_COEF_DIRECT:     coef_direct_ff     <= write_value;
            REG_COEF_FIRST_LAG:  coef_first_lag_ff  <= write_value;
            REG_COEF_SECOND_LAG: coef_second_lag_ff <= write_value;
            REG_COEF_FEEDBACK:   coef_feedback_ff   <= write_value;
            default: ;
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      case (reg_index)
         REG_COEF_DIRECT:     csr_prdata = widen(coef_direct_ff);
         REG_COEF_FIRST_LAG:  csr_prdata = widen(coef_first_lag_ff);
         REG_COEF_SECOND_LAG: csr_prdata = widen(coef_second_lag_ff);
         REG_COEF_FEEDBACK:   csr_prdata = widen(coef_feedback_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign coef_direct     = coef_direct_ff;
   assign coef_first_lag  = coef_first_lag_ff;
   assign coef_second_lag = coef_second_lag_ff;
   assign coef_feedback   = coef_feedback_ff;

endmodule

>>> rtl/core/liir_datapath.sv
// Look-ahead IIR datapath: delay lines, product registers and feedback.
// All state advances once per accepted sample; no package dependencies.
module liir_datapath #(
   parameter int SAMPLE_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic signed [SAMPLE_BITS-1:0] coef_direct,
   input  logic signed [SAMPLE_BITS-1:0] coef_first_lag,
   input  logic signed [SAMPLE_BITS-1:0] coef_second_lag,
   input  logic signed [SAMPLE_BITS-1:0] coef_feedback,
   output logic signed [SAMPLE_BITS:0]   sample_out
);

   localparam int ACC_BITS   = SAMPLE_BITS + 1;
   localparam int PROD_BITS  = SAMPLE_BITS + ACC_BITS;
   localparam int PROD_SHIFT = SAMPLE_BITS - 1;

   logic signed [SAMPLE_BITS-1:0] input_lag1_ff,        input_lag1_in;
   logic signed [SAMPLE_BITS-1:0] input_lag2_ff,        input_lag2_in;
   logic signed [ACC_BITS-1:0]    direct_prod_lag1_ff,  direct_prod_lag1_in;
   logic signed [ACC_BITS-1:0]    direct_prod_lag2_ff,  direct_prod_lag2_in;
   logic signed [ACC_BITS-1:0]    first_lag_prod_ff,    first_lag_prod_in;
   logic signed [ACC_BITS-1:0]    second_lag_prod_ff,   second_lag_prod_in;
   logic signed [ACC_BITS-1:0]    difference_ff,        difference_in;
   logic signed [ACC_BITS-1:0]    forward_sum_ff,       forward_sum_in;
   logic signed [ACC_BITS-1:0]    output_lag1_ff,       output_lag1_in;
   logic signed [ACC_BITS-1:0]    feedback_prod_ff,     feedback_prod_in;
   logic signed [ACC_BITS-1:0]    result;

   // coef * sample, floor-shifted right, wrapped to the accumulator width
   function automatic logic signed [ACC_BITS-1:0] scaled_prod(
      input logic signed [SAMPLE_BITS-1:0] coef,
      input logic signed [ACC_BITS-1:0]    sample
   );
      logic signed [PROD_BITS-1:0] a;
      logic signed [PROD_BITS-1:0] b;
      logic signed [PROD_BITS-1:0] p;
      a = {{(PROD_BITS-SAMPLE_BITS){coef[SAMPLE_BITS-1]}}, coef};
      b = {{(PROD_BITS-ACC_BITS){sample[ACC_BITS-1]}}, sample};
      p = (a * b) >>> PROD_SHIFT;
      return p[ACC_BITS-1:0];
   endfunction

   // Output sum comes straight from registered terms
   assign result = feedback_prod_ff + forward_sum_ff;

   // Next-state logic
   always_comb begin
      input_lag1_in       = sample_in;
      input_lag2_in       = input_lag1_ff;
      direct_prod_lag1_in = scaled_prod(coef_direct, {sample_in[SAMPLE_BITS-1], sample_in});
      direct_prod_lag2_in = direct_prod_lag1_ff;
      first_lag_prod_in   = scaled_prod(coef_first_lag,
                                        {input_lag1_ff[SAMPLE_BITS-1], input_lag1_ff});
      second_lag_prod_in  = scaled_prod(coef_second_lag,
                                        {input_lag2_ff[SAMPLE_BITS-1], input_lag2_ff});
      difference_in       = first_lag_prod_ff - second_lag_prod_ff;
      forward_sum_in      = direct_prod_lag2_ff + difference_ff;
      output_lag1_in      = result;
      feedback_prod_in    = scaled_prod(coef_feedback, output_lag1_ff);
   end

   // Filter state, one step per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         input_lag1_ff       <= '0;
         input_lag2_ff       <= '0;
         direct_prod_lag1_ff <= '0;
         direct_prod_lag2_ff <= '0;
         first_lag_prod_ff   <= '0;
         second_lag_prod_ff  <= '0;
         difference_ff       <= '0;
         forward_sum_ff      <= '0;
         output_lag1_ff      <= '0;
         feedback_prod_ff    <= '0;
      end else if (advance) begin
         input_lag1_ff       <= input_lag1_in;
         input_lag2_ff       <= input_lag2_in;
         direct_prod_lag1_ff <= direct_prod_lag1_in;
         direct_prod_lag2_ff <= direct_prod_lag2_in;
         first_lag_prod_ff   <= first_lag_prod_in;
         second_lag_prod_ff  <= second_lag_prod_in;
         difference_ff       <= difference_in;
         forward_sum_ff      <= forward_sum_in;
         output_lag1_ff      <= output_lag1_in;
         feedback_prod_ff    <= feedback_prod_in;
      end
   end

   assign sample_out = result;

endmodule

>>> test/tb_lookahead_iir_first_order.sv
// Self-checking testbench for the look-ahead first-order IIR filter.
// Needs liir_pkg and the RTL of lookahead_iir_first_order; drives beats with
// random idling and coefficient writes over the register port.
module tb_lookahead_iir_first_order;
   import liir_pkg::*;

   localparam int SAMPLE_BITS = 11;
   localparam int ACC_BITS    = SAMPLE_BITS + 1;
   localparam int HOLD_CYCLES = 80;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   // Filter predictor plus queue of outputs still owed by the block
   class liir_checker;
      sample_type coef [4];
      sample_type x_lag1, x_lag2;
      acc_type    direct_d1, direct_d2, first_prod, second_prod;
      acc_type    diff_q, fwd_sum_q, y_lag1, fb_prod;
      acc_type    expected_out [$];
      int         n_samples, n_outputs, n_errors;

      function new();
         coef[REG_COEF_DIRECT]     = sample_type'(COEF_DIRECT_RESET);
         coef[REG_COEF_FIRST_LAG]  = sample_type'(COEF_FIRST_LAG_RESET);
         coef[REG_COEF_SECOND_LAG] = sample_type'(COEF_SECOND_LAG_RESET);
         coef[REG_COEF_FEEDBACK]   = sample_type'(COEF_FEEDBACK_RESET);
         x_lag1 = '0; x_lag2 = '0;
         direct_d1 = '0; direct_d2 = '0; first_prod = '0; second_prod = '0;
         diff_q = '0; fwd_sum_q = '0; y_lag1 = '0; fb_prod = '0;
      endfunction

      // coefficient times sample, floor shift, wrap to accumulator width
      static function acc_type scaled(int c, int s);
         int p;
         p = (c * s) >>> (SAMPLE_BITS - 1);
         return p[ACC_BITS-1:0];
      endfunction

      function void report(string msg);
         n_errors++;
         if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void set_coef(reg_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         coef[idx] = v[SAMPLE_BITS-1:0];
      endfunction

      function void check_coef(reg_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         if (v[SAMPLE_BITS-1:0] !== coef[idx])
            report($sformatf("%s readback: expected %0d, got %0d", idx.name(),
                             coef[idx], $signed(v[SAMPLE_BITS-1:0])));
      endfunction

      // one accepted input beat advances the whole pipeline
      function void take_sample(sample_type x);
         acc_type p_direct, p_first, p_second, d, f, p_fb, y;
         p_direct = scaled(coef[REG_COEF_DIRECT], x);
         p_first  = scaled(coef[REG_COEF_FIRST_LAG], x_lag1);
         p_second = scaled(coef[REG_COEF_SECOND_LAG], x_lag2);
         d        = first_prod - second_prod;
         f        = direct_d2 + diff_q;
         p_fb     = scaled(coef[REG_COEF_FEEDBACK], y_lag1);
         y        = fb_prod + fwd_sum_q;
         y_lag1 = y;
         x_lag2 = x_lag1;
         x_lag1 = x;
         direct_d2 = direct_d1;
         direct_d1 = p_direct;
         first_prod = p_first;
         second_prod = p_second;
         diff_q = d;
         fwd_sum_q = f;
         fb_prod = p_fb;
         expected_out.push_back(y);
         n_samples++;
      endfunction

      function void check_output(acc_type y);
         acc_type want;
         n_outputs++;
         if (expected_out.size() == 0) begin
            report($sformatf("output beat %0d with nothing pending", y));
            return;
         end
         want = expected_out.pop_front();
         if (y !== want)
            report($sformatf("sample_out: expected %0d, got %0d", want, y));
      endfunction

      function int pending();
         return expected_out.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   sample_type               req_sample_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   acc_type                  rsp_sample_out;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   liir_checker chk = new();
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  n_settings = 0;

   lookahead_iir_first_order #(.SAMPLE_BITS(SAMPLE_BITS)) uut (.*);

   always #4 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("tb_lookahead_iir_first_order: errors");
      $finish;
   end

   // Beat monitor: results checked before the new input is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) chk.check_output(rsp_sample_out);
         if (req_valid && !req_stall) chk.take_sample(req_sample_in);
      end
   end

   // Output side back-pressure: random stalls plus one long hold
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(sample_type x);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed output has come out
   task automatic drain();
      req_valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup and access phases, then an idle phase before the next transfer
   task automatic csr_access(reg_index_type idx, logic wr, logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_ADDR_BITS'(int'(idx) << CSR_WORD_LSB);
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write one coefficient, then read it back
   task automatic set_coef(reg_index_type idx, int c);
      logic [CSR_DATA_BITS-1:0] wdata, rdata;
      wdata = $urandom;
      wdata[SAMPLE_BITS-1:0] = c[SAMPLE_BITS-1:0];
      csr_access(idx, 1'b1, wdata, rdata);
      chk.set_coef(idx, wdata);
      csr_access(idx, 1'b0, '0, rdata);
      chk.check_coef(idx, rdata);
   endtask

   task automatic set_all(int c0, int c1, int c2, int c3);
      set_coef(REG_COEF_DIRECT, c0);
      set_coef(REG_COEF_FIRST_LAG, c1);
      set_coef(REG_COEF_SECOND_LAG, c2);
      set_coef(REG_COEF_FEEDBACK, c3);
      n_settings++;
   endtask

   function automatic int pick_value();
      case ($urandom_range(7))
         0: return -1024;
         1: return 1023;
         2: return 0;
         3: return -1;
         default: return int'($urandom_range(2047)) - 1024;
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_BITS-1:0] rd;
      int phase, k;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coefficient defaults after reset
      csr_access(REG_COEF_DIRECT, 1'b0, '0, rd);     chk.check_coef(REG_COEF_DIRECT, rd);
      csr_access(REG_COEF_FIRST_LAG, 1'b0, '0, rd);  chk.check_coef(REG_COEF_FIRST_LAG, rd);
      csr_access(REG_COEF_SECOND_LAG, 1'b0, '0, rd); chk.check_coef(REG_COEF_SECOND_LAG, rd);
      csr_access(REG_COEF_FEEDBACK, 1'b0, '0, rd);   chk.check_coef(REG_COEF_FEEDBACK, rd);

      // directed: sample extremes and bit patterns under default coefficients
      send_beat(0);     send_beat(1023);  send_beat(-1024); send_beat(-1);
      send_beat(1);     send_beat(-1024); send_beat(1023);  send_beat(0);
      send_beat(341);   send_beat(-342);
      drain();

      // directed: extreme coefficients drive products and sums into wraparound
      set_all(-1024, -1024, 1023, -1024);
      repeat (4) send_beat(-1024);
      repeat (4) send_beat(1023);
      send_beat(-1024); send_beat(1023); send_beat(-1024); send_beat(0);
      drain();

      // random phases, rotating idle patterns and coefficient settings
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: set_all(1023, 1023, 1023, 1023);
            1: set_all(-1024, -1024, -1024, -1024);
            2: set_all(0, 0, 0, 0);
            8: set_all(COEF_DIRECT_RESET, COEF_FIRST_LAG_RESET,
                       COEF_SECOND_LAG_RESET, COEF_FEEDBACK_RESET);
            default: set_all(pick_value(), pick_value(), pick_value(), pick_value());
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         // long output hold while the input keeps pushing
         if (phase == 4) begin
            @(posedge clock);
            hold_request = 1'b1;
            @(negedge clock);
         end
         for (k = 0; k < 105; k++) send_beat(sample_type'(pick_value()));
         drain();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);

      $display("Covered %0d samples in, %0d outputs out, over %0d coefficient settings,",
               chk.n_samples, chk.n_outputs, n_settings);
      $display("with input gaps, output stalls and one long output hold; %0d errors.",
               chk.n_errors);
      if (chk.n_errors == 0 && chk.pending() == 0) begin
         $display("tb_lookahead_iir_first_order: clean");
      end else begin
         $display("tb_lookahead_iir_first_order: errors");
      end
      $finish;
   end

endmodule
